>>> hw/rtl/sitda_pkg.sv
package sitda_pkg;

  localparam int unsigned VAL_W = 32;                  // input integer width
  localparam int unsigned DIG_N = 10;                  // decimal digits of a 32-bit magnitude
  localparam int unsigned DIG_W = 4;                   // bits per BCD digit
  localparam int unsigned BCD_W = DIG_N * DIG_W;       // packed BCD width
  localparam int unsigned SHF_W = $clog2(VAL_W + 1);   // shift counter width
  localparam int unsigned DCN_W = $clog2(DIG_N + 1);   // digit counter width
  localparam int unsigned CHR_W = 8;                   // ASCII character width

  localparam logic [CHR_W-1:0] CHR_MINUS = 8'h2D;      // '-'
  localparam logic [CHR_W-1:0] CHR_ZERO  = 8'h30;      // '0'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } sitda_state_t;

  // converter -> top: finished BCD image
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } sitda_bcd_t;

  // top -> emitter: start a character run
  typedef struct packed {
    logic             load;
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } sitda_load_t;

endpackage

>>> hw/rtl/signed_int_to_decimal_ascii_core.sv
// Channel  | Dir | Ports                        | Beat content
// in_      | in  | tvalid, tready, tdata[31:0]  | value (signed 32-bit integer)
// out_     | out | tvalid, tready, tdata[7:0]   | char_code ('-' or '0'..'9'), tlast = last_char
//
// One integer at a time. After the accept beat the magnitude is shifted into
// a BCD register one bit per cycle, then the digit sequencer is loaded, then
// the ten digit slots are stepped through (skipped leading zeros included),
// with one more slot for the sign when the value is negative.
// rst_n is synchronous, active low, and clears all control state. A stall on
// out_tready holds the output register and the digit sequencer; in_tready
// stays low until the last character of the current run has been taken.
module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] char_code
  output logic        out_tlast    // last_char
);

  sitda_pkg::sitda_state_t state_r, state_nxt;
  sitda_pkg::sitda_bcd_t   bcd_res;
  sitda_pkg::sitda_load_t  emit_ld;

  logic                           neg_r;
  logic                           in_acc;
  logic                           emit_busy;
  logic [sitda_pkg::VAL_W-1:0]    mag;

  assign in_acc = in_tvalid && in_tready;

  // magnitude: the most negative value wraps to 2^31, which is right as unsigned
  assign mag = in_tdata[sitda_pkg::VAL_W-1] ? (~in_tdata + sitda_pkg::VAL_W'(1)) : in_tdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sitda_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = sitda_pkg::ST_CONV;
      end
      sitda_pkg::ST_CONV: begin
        if (bcd_res.done) state_nxt = sitda_pkg::ST_EMIT;
      end
      sitda_pkg::ST_EMIT: begin
        if (!emit_busy) state_nxt = sitda_pkg::ST_IDLE;
      end
      default: state_nxt = sitda_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready    = 1'b0;
    emit_ld.load = 1'b0;
    emit_ld.neg  = neg_r;
    emit_ld.bcd  = bcd_res.bcd;
    case (state_r)
      sitda_pkg::ST_IDLE: in_tready    = 1'b1;
      sitda_pkg::ST_CONV: emit_ld.load = bcd_res.done;
      sitda_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the sign for the run
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r <= in_tdata[sitda_pkg::VAL_W-1];
    end
  end

  sitda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .mag   (mag),
    .res   (bcd_res)
  );

  sitda_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (emit_ld),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // characters appear only while a run is being emitted
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == sitda_pkg::ST_EMIT)
    else $error("output beat outside emit phase");

  // an accepted integer always starts a conversion
  a_acc_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == sitda_pkg::ST_CONV)
    else $error("accept did not start conversion");

  // a minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == sitda_pkg::CHR_MINUS) |-> !out_tlast)
    else $error("sign marked as last character");

  // conversion finishes only while waiting for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    bcd_res.done |-> state_r == sitda_pkg::ST_CONV)
    else $error("BCD done outside conversion");

endmodule

>>> hw/rtl/sitda_dabble.sv
// Bit-serial shift-and-add-3 binary to BCD converter: one magnitude bit per cycle.
module sitda_dabble (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sitda_pkg::VAL_W-1:0]      mag,
  output sitda_pkg::sitda_bcd_t            res
);

  logic [sitda_pkg::VAL_W-1:0] sh_r;
  logic [sitda_pkg::BCD_W-1:0] bcd_r;
  logic [sitda_pkg::BCD_W-1:0] adj;
  logic [sitda_pkg::SHF_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sitda_pkg::DIG_N; i++) begin
      if (bcd_r[i*sitda_pkg::DIG_W +: sitda_pkg::DIG_W] >= 4'd5) begin
        adj[i*sitda_pkg::DIG_W +: sitda_pkg::DIG_W] =
          bcd_r[i*sitda_pkg::DIG_W +: sitda_pkg::DIG_W] + 4'd3;
      end else begin
        adj[i*sitda_pkg::DIG_W +: sitda_pkg::DIG_W] =
          bcd_r[i*sitda_pkg::DIG_W +: sitda_pkg::DIG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= sitda_pkg::SHF_W'(sitda_pkg::VAL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - sitda_pkg::SHF_W'(1);
        if (cnt_r == sitda_pkg::SHF_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[sitda_pkg::VAL_W-2:0], 1'b0};
      bcd_r <= {adj[sitda_pkg::BCD_W-2:0], sh_r[sitda_pkg::VAL_W-1]};
    end
  end

  assign res.done = done_r;
  assign res.bcd  = bcd_r;

endmodule

>>> hw/rtl/sitda_emit.sv
// Character sequencer: sign, then one BCD digit per cycle while out_tready does not stall it, leading zeros dropped.
module sitda_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sitda_pkg::sitda_load_t             ld,
  output logic                               busy,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sitda_pkg::CHR_W-1:0]        out_tdata,
  output logic                               out_tlast
);

  logic [sitda_pkg::BCD_W-1:0] dig_r;
  logic [sitda_pkg::DCN_W-1:0] cnt_r;
  logic                        sgn_r;
  logic                        skip_r;
  logic                        vld_r;
  logic [sitda_pkg::CHR_W-1:0] chr_r;
  logic                        lst_r;
  logic                        go;
  logic [sitda_pkg::DIG_W-1:0] top_dig;
  logic                        last_dig;

  assign go       = !vld_r || out_tready;
  assign top_dig  = dig_r[sitda_pkg::BCD_W-1 -: sitda_pkg::DIG_W];
  assign last_dig = (cnt_r == sitda_pkg::DCN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      sgn_r  <= 1'b0;
      skip_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ld.load) begin
      sgn_r  <= ld.neg;
      skip_r <= 1'b1;
      cnt_r  <= sitda_pkg::DCN_W'(sitda_pkg::DIG_N);
    end else if (go) begin
      vld_r <= 1'b0;
      if (sgn_r) begin
        vld_r <= 1'b1;
        sgn_r <= 1'b0;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - sitda_pkg::DCN_W'(1);
        // drop a leading zero unless it is the only digit left
        if (!(skip_r && top_dig == '0 && !last_dig)) begin
          vld_r  <= 1'b1;
          skip_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      dig_r <= ld.bcd;
    end else if (go && !sgn_r && cnt_r != '0) begin
      dig_r <= {dig_r[sitda_pkg::BCD_W-sitda_pkg::DIG_W-1:0], {sitda_pkg::DIG_W{1'b0}}};
    end
    if (!ld.load && go) begin
      if (sgn_r) begin
        chr_r <= sitda_pkg::CHR_MINUS;
        lst_r <= 1'b0;
      end else if (cnt_r != '0) begin
        chr_r <= sitda_pkg::CHR_ZERO | sitda_pkg::CHR_W'(top_dig);
        lst_r <= last_dig;
      end
    end
  end

  assign busy       = vld_r || sgn_r || (cnt_r != '0);
  assign out_tvalid = vld_r;
  assign out_tdata  = chr_r;
  assign out_tlast  = lst_r;

endmodule
